@@ hdl/dnoc_pkg.sv @@
// shared types, constants and the cp-1252 high-range table for the directory
// name order compare block; no dependencies
package dnoc_pkg;

   typedef logic [15:0]        unit_type;
   typedef logic signed [1:0]  order_type;

   typedef struct packed {
      logic       first_pair;
      logic       pair_valid;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] length_a;
      logic [7:0] length_b;
      logic       last_pair;
   } beat_type;

   localparam order_type ORDER_BEFORE = 2'sb11;
   localparam order_type ORDER_EQUAL  = 2'sb00;
   localparam order_type ORDER_AFTER  = 2'sb01;

   localparam logic [7:0] HI_FIRST = 8'h80;
   localparam logic [7:0] HI_LAST  = 8'h9F;

   localparam unit_type CASE_OFFSET   = 16'h0020;
   localparam unit_type ASCII_LOW_A   = 16'h0061;
   localparam unit_type ASCII_LOW_Z   = 16'h007A;
   localparam unit_type LATIN_LOW_LO  = 16'h00E0;
   localparam unit_type LATIN_LOW_HI  = 16'h00FE;
   localparam unit_type LATIN_DIVIDE  = 16'h00F7;
   localparam unit_type Y_DIAERESIS   = 16'h00FF;
   localparam unit_type Y_DIAER_UPPER = 16'h0178;
   localparam unit_type MICRO_SIGN    = 16'h00B5;
   localparam unit_type MU_UPPER      = 16'h039C;
   localparam unit_type S_CARON       = 16'h0161;
   localparam unit_type Z_CARON       = 16'h017E;
   localparam unit_type OE_LIGATURE   = 16'h0153;
   localparam unit_type F_HOOK        = 16'h0192;
   localparam unit_type ONE_UNIT      = 16'h0001;

   localparam unit_type HI_TABLE [32] = '{
      16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
      16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
   };

endpackage

@@ hdl/dnoc_fold.sv @@
// maps one cp-1252 byte to its code unit and folds it to upper case
// depends on dnoc_pkg
module dnoc_fold (
   input  logic [7:0]         byte_in,
   output dnoc_pkg::unit_type unit_out
);

   dnoc_pkg::unit_type unit;

   always_comb begin
      if (byte_in inside {[dnoc_pkg::HI_FIRST:dnoc_pkg::HI_LAST]}) begin
         unit = dnoc_pkg::HI_TABLE[byte_in[4:0]];
      end else begin
         unit = {8'h00, byte_in};
      end
   end

   always_comb begin
      if (unit inside {[dnoc_pkg::ASCII_LOW_A:dnoc_pkg::ASCII_LOW_Z]}) begin
         unit_out = unit - dnoc_pkg::CASE_OFFSET;
      end else if (unit inside {[dnoc_pkg::LATIN_LOW_LO:dnoc_pkg::LATIN_LOW_HI]} &&
                   unit != dnoc_pkg::LATIN_DIVIDE) begin
         unit_out = unit - dnoc_pkg::CASE_OFFSET;
      end else begin
         case (unit)
            dnoc_pkg::Y_DIAERESIS: unit_out = dnoc_pkg::Y_DIAER_UPPER;
            dnoc_pkg::MICRO_SIGN:  unit_out = dnoc_pkg::MU_UPPER;
            dnoc_pkg::S_CARON,
            dnoc_pkg::Z_CARON,
            dnoc_pkg::OE_LIGATURE,
            dnoc_pkg::F_HOOK:      unit_out = unit - dnoc_pkg::ONE_UNIT;
            default:               unit_out = unit;
         endcase
      end
   end

endmodule

@@ hdl/directory_name_order_compare_top.sv @@
// directory name order compare: top level with input stage, verdict state and result register
// depends on dnoc_pkg and dnoc_fold
//
// usage:
//   req channel carries one byte of each name per beat plus both name lengths.
//   tuser flags first_pair (start of a comparison) and pair_valid (bytes present);
//   tlast marks the final beat of a comparison.
//   rsp channel returns one beat per req beat with tlast set: the 2-bit signed order
//   (-1 first name sorts before, 0 equal, 1 sorts after).
//   a shorter name sorts first; at equal lengths the first unequal folded byte pair
//   decides. the running verdict is cleared only by first_pair or reset.
// result path: the last beat goes through the input register, then the result
//   register, which drives rsp_tvalid.
// throughput: one beat per cycle unless a last beat waits on a stalled result; the table
//   lookup, case fold and 16-bit compare are combinational, input reg to verdict/result regs.
// reset: synchronous, clears both stages and the verdict; req_tready is high after.
// stall: while a result waits on rsp_tready, beats without tlast keep flowing; a
//   beat with tlast waits in the input register and req_tready drops until the
//   result register frees.
module directory_name_order_compare_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // byte_a, byte_b, length_a, length_b
   input  logic [1:0]  req_tuser,  // first_pair, pair_valid
   input  logic        req_tlast,  // last_pair
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // order, zero padding
);

   logic                s1_valid_ff, s1_valid_in;
   dnoc_pkg::beat_type  s1_beat_ff, s1_beat_in;
   logic                found_ff, found_in;
   dnoc_pkg::order_type running_ff, running_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dnoc_pkg::order_type rsp_order_ff, rsp_order_in;

   logic                s1_advance;
   logic                rsp_load;
   logic                req_accept;
   dnoc_pkg::unit_type  unit_a;
   dnoc_pkg::unit_type  unit_b;
   logic                found_base;
   dnoc_pkg::order_type running_base;
   dnoc_pkg::order_type result_order;

   dnoc_fold fold_a (
      .byte_in  (s1_beat_ff.byte_a),
      .unit_out (unit_a)
   );

   dnoc_fold fold_b (
      .byte_in  (s1_beat_ff.byte_b),
      .unit_out (unit_b)
   );

   assign s1_advance = s1_valid_ff &&
                       (!s1_beat_ff.last_pair || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = s1_advance && s1_beat_ff.last_pair;

   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      s1_beat_in  = s1_beat_ff;
      if (req_accept) begin
         s1_beat_in.first_pair = req_tuser[0];
         s1_beat_in.pair_valid = req_tuser[1];
         s1_beat_in.byte_a     = req_tdata[7:0];
         s1_beat_in.byte_b     = req_tdata[15:8];
         s1_beat_in.length_a   = req_tdata[23:16];
         s1_beat_in.length_b   = req_tdata[31:24];
         s1_beat_in.last_pair  = req_tlast;
      end
   end

   // verdict update for the beat in the input register
   always_comb begin
      found_base   = s1_beat_ff.first_pair ? 1'b0 : found_ff;
      running_base = s1_beat_ff.first_pair ? dnoc_pkg::ORDER_EQUAL : running_ff;
      found_in     = found_ff;
      running_in   = running_ff;
      if (s1_advance) begin
         found_in   = found_base;
         running_in = running_base;
         if (s1_beat_ff.pair_valid && s1_beat_ff.length_a == s1_beat_ff.length_b &&
             !found_base && unit_a != unit_b) begin
            found_in   = 1'b1;
            running_in = (unit_a < unit_b) ? dnoc_pkg::ORDER_BEFORE : dnoc_pkg::ORDER_AFTER;
         end
      end
   end

   always_comb begin
      if (s1_beat_ff.length_a != s1_beat_ff.length_b) begin
         result_order = (s1_beat_ff.length_a < s1_beat_ff.length_b) ?
                        dnoc_pkg::ORDER_BEFORE : dnoc_pkg::ORDER_AFTER;
      end else begin
         result_order = running_in;
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_order_in = rsp_load ? result_order : rsp_order_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         running_ff   <= dnoc_pkg::ORDER_EQUAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         found_ff     <= found_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_beat_ff   <= s1_beat_in;
      rsp_order_ff <= rsp_order_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_order_ff};

   // new result only from a last beat leaving the input stage
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_beat_ff.last_pair))
      else $error("result appeared without a last beat");

   // held verdict is consistent with its flag
   a_verdict_consistent: assert property (@(posedge clock) disable iff (reset)
      (found_ff && running_ff != dnoc_pkg::ORDER_EQUAL) ||
      (!found_ff && running_ff == dnoc_pkg::ORDER_EQUAL))
      else $error("running order disagrees with verdict flag");

   // a waiting last beat is not overwritten while the result is stalled
   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_beat_ff.last_pair && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input stage accepted while last beat was stalled");

   // result register never holds the unused order code
   a_order_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_order_ff == dnoc_pkg::ORDER_BEFORE ||
                        rsp_order_ff == dnoc_pkg::ORDER_EQUAL ||
                        rsp_order_ff == dnoc_pkg::ORDER_AFTER))
      else $error("invalid order code in result");

endmodule
